/* design/pdfls_pkg.sv */
// Shared types and constants for the PDF literal string unescape block.
package pdfls_pkg;

    localparam int COUNT_BITS = 16;
    localparam int MAX_RES    = 3;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [7:0] CHR_LF     = 8'o012;
    localparam logic [7:0] CHR_CR     = 8'o015;
    localparam logic [7:0] CHR_TAB    = 8'o011;
    localparam logic [7:0] CHR_BS     = 8'o010;
    localparam logic [7:0] CHR_FF     = 8'o014;
    localparam logic [7:0] CHR_LPAREN = 8'h28;
    localparam logic [7:0] CHR_RPAREN = 8'h29;
    localparam logic [7:0] CHR_BSLASH = 8'h5C;
    localparam logic [7:0] CHR_N      = 8'h6E;
    localparam logic [7:0] CHR_R      = 8'h72;
    localparam logic [7:0] CHR_T      = 8'h74;
    localparam logic [7:0] CHR_B      = 8'h62;
    localparam logic [7:0] CHR_F      = 8'h66;
    localparam logic [7:0] CHR_ZERO   = 8'h30;
    localparam logic [7:0] CHR_SEVEN  = 8'h37;

    localparam logic [7:0] DEPTH_MAX  = 8'hFF;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_data;
    } in_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_end;
        logic [15:0] decoded_length;
        logic        last;
    } out_t;

    typedef struct packed {
        logic [7:0]            paren_depth;
        logic                  escape_pending;
        logic                  skip_linefeed;
        logic [1:0]            octal_digits_seen;
        logic [7:0]            octal_value;
        logic [COUNT_BITS-1:0] byte_count;
    } state_t;

    localparam state_t STATE_RESET = '{
        paren_depth:       8'd1,
        escape_pending:    1'b0,
        skip_linefeed:     1'b0,
        octal_digits_seen: 2'd0,
        octal_value:       8'd0,
        byte_count:        '0
    };

    // Length reported on the end result, clipped to 16 bits.
    function automatic logic [15:0] clip_len(input logic [COUNT_BITS-1:0] cnt);
        logic [COUNT_BITS+15:0] wide;
        wide = {16'd0, cnt};
        if (wide > (COUNT_BITS+16)'(17'h0FFFF))
            clip_len = 16'hFFFF;
        else
            clip_len = wide[15:0];
    endfunction

    function automatic logic is_octal(input logic [7:0] c);
        is_octal = (c >= CHR_ZERO) && (c <= CHR_SEVEN);
    endfunction

endpackage

/* design/pdfls_decode.sv */
// Per-byte decode: current state and one raw byte in, up to three results out.
module pdfls_decode (
    input  pdfls_pkg::state_t st_cur,
    input  pdfls_pkg::in_t    in_item,
    output pdfls_pkg::state_t st_next,
    output pdfls_pkg::out_t   res [pdfls_pkg::MAX_RES],
    output logic [1:0]        res_n
);

    always_comb
    begin
        pdfls_pkg::state_t st;
        logic [7:0] c;
        logic       closed;
        logic       used;
        logic [1:0] n;

        st     = st_cur;
        c      = in_item.in_byte;
        closed = 1'b0;
        used   = 1'b0;
        n      = 2'd0;
        for (int i = 0; i < pdfls_pkg::MAX_RES; i++)
            res[i] = '0;

        // octal escape in progress
        if (st.octal_digits_seen != 2'd0)
        begin
            if (pdfls_pkg::is_octal(c))
            begin
                st.octal_value       = {st.octal_value[4:0], c[2:0]};
                st.octal_digits_seen = st.octal_digits_seen + 2'd1;
                if (st.octal_digits_seen == 2'd3)
                begin
                    res[n].out_byte = st.octal_value;
                    n = n + 2'd1;
                    if (st.byte_count != pdfls_pkg::CNT_MAX)
                        st.byte_count = st.byte_count + 1'b1;
                    st.octal_digits_seen = 2'd0;
                    st.octal_value       = 8'd0;
                end
                used = 1'b1;
            end
            else
            begin
                res[n].out_byte = st.octal_value;
                n = n + 2'd1;
                if (st.byte_count != pdfls_pkg::CNT_MAX)
                    st.byte_count = st.byte_count + 1'b1;
                st.octal_digits_seen = 2'd0;
                st.octal_value       = 8'd0;
            end
        end

        // LF right after a CR
        if (!used && st.skip_linefeed)
        begin
            st.skip_linefeed = 1'b0;
            if (c == pdfls_pkg::CHR_LF)
                used = 1'b1;
        end

        // byte after a backslash
        if (!used && st.escape_pending)
        begin
            logic       emit;
            logic [7:0] b;
            emit = 1'b1;
            b    = c;
            st.escape_pending = 1'b0;
            used = 1'b1;
            case (c)
                pdfls_pkg::CHR_CR:
                begin
                    st.skip_linefeed = 1'b1;
                    emit = 1'b0;
                end
                pdfls_pkg::CHR_LF: emit = 1'b0;
                pdfls_pkg::CHR_N:  b = pdfls_pkg::CHR_LF;
                pdfls_pkg::CHR_R:  b = pdfls_pkg::CHR_CR;
                pdfls_pkg::CHR_T:  b = pdfls_pkg::CHR_TAB;
                pdfls_pkg::CHR_B:  b = pdfls_pkg::CHR_BS;
                pdfls_pkg::CHR_F:  b = pdfls_pkg::CHR_FF;
                default:
                begin
                    if (pdfls_pkg::is_octal(c))
                    begin
                        st.octal_value       = {5'd0, c[2:0]};
                        st.octal_digits_seen = 2'd1;
                        emit = 1'b0;
                    end
                end
            endcase
            if (emit)
            begin
                res[n].out_byte = b;
                n = n + 2'd1;
                if (st.byte_count != pdfls_pkg::CNT_MAX)
                    st.byte_count = st.byte_count + 1'b1;
            end
        end

        // plain byte
        if (!used)
        begin
            logic       emit;
            logic [7:0] b;
            emit = 1'b1;
            b    = c;
            case (c)
                pdfls_pkg::CHR_CR:
                begin
                    b = pdfls_pkg::CHR_LF;
                    st.skip_linefeed = 1'b1;
                end
                pdfls_pkg::CHR_LPAREN:
                begin
                    if (st.paren_depth != pdfls_pkg::DEPTH_MAX)
                        st.paren_depth = st.paren_depth + 8'd1;
                end
                pdfls_pkg::CHR_RPAREN:
                begin
                    if (st.paren_depth <= 8'd1)
                    begin
                        closed = 1'b1;
                        emit   = 1'b0;
                    end
                    else
                        st.paren_depth = st.paren_depth - 8'd1;
                end
                pdfls_pkg::CHR_BSLASH:
                begin
                    st.escape_pending = 1'b1;
                    emit = 1'b0;
                end
                default: emit = 1'b1;
            endcase
            if (emit)
            begin
                res[n].out_byte = b;
                n = n + 2'd1;
                if (st.byte_count != pdfls_pkg::CNT_MAX)
                    st.byte_count = st.byte_count + 1'b1;
            end
        end

        // data ran out: flush a pending octal byte, then close
        if (!closed && in_item.end_of_data)
        begin
            if (st.octal_digits_seen != 2'd0)
            begin
                res[n].out_byte = st.octal_value;
                n = n + 2'd1;
                if (st.byte_count != pdfls_pkg::CNT_MAX)
                    st.byte_count = st.byte_count + 1'b1;
            end
            closed = 1'b1;
        end

        if (closed)
        begin
            res[n].is_end         = 1'b1;
            res[n].decoded_length = pdfls_pkg::clip_len(st.byte_count);
            n  = n + 2'd1;
            st = pdfls_pkg::STATE_RESET;
        end

        for (int i = 0; i < pdfls_pkg::MAX_RES; i++)
            if (n != 2'd0 && 2'(i) == n - 2'd1)
                res[i].last = 1'b1;

        st_next = st;
        res_n   = n;
    end

endmodule

/* design/pdf_literal_string_unescape.sv */
// Top level of the PDF literal string unescape block.
//
// Usage:
//   in_*  : one raw byte of a literal string body per transaction (the bytes
//           after the opening parenthesis), with end_of_data on the last
//           available byte.
//   out_* : decoded bytes, then one end transaction (is_end = 1) carrying the
//           decoded length. last marks the final result caused by one input.
// Each input byte is decoded in the cycle it is accepted into a group
// register of up to three results; the group drains one result per cycle
// into the output register while out_stall is low. A byte's first output
// passes the group register, then the output register. Throughput: one
// input byte per cycle while each yields at most one result and out_stall
// is low; a byte with more results stalls the input until they drain.
// The input is taken while a result waits stalled in the output register,
// as long as the group register is free or empties this cycle.
// Reset clears the decode state (depth 1, no escape pending, count 0) and
// both the group and output valid flags. A stall on the output holds the
// output transaction stable and backs up into in_stall.
module pdf_literal_string_unescape (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  pdfls_pkg::in_t   in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output pdfls_pkg::out_t  out_data
);

    pdfls_pkg::state_t st_reg;
    pdfls_pkg::state_t st_next;
    pdfls_pkg::out_t   dec_res [pdfls_pkg::MAX_RES];
    logic [1:0]        dec_n;

    pdfls_pkg::out_t   grp_reg [pdfls_pkg::MAX_RES];
    logic [1:0]        grp_cnt_reg;
    logic [1:0]        grp_idx_reg;

    pdfls_pkg::out_t   out_reg;
    logic              out_valid_reg;

    logic out_take;
    logic out_load;
    logic grp_free;
    logic in_accept;

    pdfls_decode u_decode (
        .st_cur  (st_reg),
        .in_item (in_data),
        .st_next (st_next),
        .res     (dec_res),
        .res_n   (dec_n)
    );

    // output register moves on when empty or when its transaction is taken
    assign out_take  = out_valid_reg && !out_stall;
    assign out_load  = (grp_cnt_reg != 2'd0) && (!out_valid_reg || out_take);
    // group register frees up when its last pending result moves out
    assign grp_free  = (grp_cnt_reg == 2'd0) || ((grp_cnt_reg == 2'd1) && out_load);
    assign in_stall  = !grp_free;
    assign in_accept = in_valid && grp_free;

    // decode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= pdfls_pkg::STATE_RESET;
        else if (in_accept)
            st_reg <= st_next;
    end

    // group control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_cnt_reg <= 2'd0;
            grp_idx_reg <= 2'd0;
        end
        else if (in_accept)
        begin
            grp_cnt_reg <= dec_n;
            grp_idx_reg <= 2'd0;
        end
        else if (out_load)
        begin
            grp_cnt_reg <= grp_cnt_reg - 2'd1;
            grp_idx_reg <= grp_idx_reg + 2'd1;
        end
    end

    // group payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
            grp_reg <= dec_res;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_take)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= grp_reg[grp_idx_reg];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // an end result returns the decoder to its reset state
    a_end_resets_state: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && dec_n != 2'd0 && dec_res[dec_n - 2'd1].is_end
        |=> st_reg.paren_depth == 8'd1 && st_reg.byte_count == '0
            && !st_reg.escape_pending && st_reg.octal_digits_seen == 2'd0)
        else $error("state not cleared after end of string");

    // the final result of a group carries last
    a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && grp_cnt_reg == 2'd1 |=> out_reg.last)
        else $error("final result of a group lacks last");

    a_no_early_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && grp_cnt_reg > 2'd1 |=> !out_reg.last)
        else $error("last set before the final result of a group");

    // the end result carries no byte
    a_end_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.is_end |-> out_reg.out_byte == 8'd0)
        else $error("end result carries a byte");

    // octal collection never rests at three digits
    a_octal_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.octal_digits_seen != 2'd3)
        else $error("octal digit count reached three without flush");

endmodule
